@@ rtl/grid_neighbor_finder_macros.svh @@
// Assertion macros shared by the grid neighbour finder modules.
`ifndef GRID_NEIGHBOR_FINDER_MACROS_SVH
`define GRID_NEIGHBOR_FINDER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GNF_ASSERT_IMPL(label, clk, rstn, ante, cons) \
label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("gnf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GNF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("gnf assertion failed");

`endif

@@ rtl/gnf_pkg.sv @@
package gnf_pkg;

    localparam int COORD_W    = 8;
    localparam int DIM_W      = COORD_W + 1;
    localparam int POS_W      = COORD_W + 2;
    localparam int ADDR_W     = 2 * COORD_W;
    localparam int MAX_WIDTH  = 1 << COORD_W;
    localparam int MAX_HEIGHT = 1 << COORD_W;
    localparam int NUM_DIRS   = 8;
    localparam int DIR_W      = 3;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_CROSS = 2'd1;
    localparam logic [1:0] MODE_EIGHT = 2'd2;

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    localparam int IN_BITS = 3 * COORD_W + 2;

    typedef struct packed {
        logic               wall_bit;
        logic               corner_needs_sides;
        logic [COORD_W-1:0] distance;
        logic [COORD_W-1:0] node_y;
        logic [COORD_W-1:0] node_x;
    } in_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] ny;
        logic signed [POS_W-1:0] nx;
    } pos_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic                eight;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  d;
        logic [NUM_DIRS-1:0] mask;
    } scan_res_t;

    function automatic pos_t neighbor_pos(input logic [COORD_W-1:0] x,
                                          input logic [COORD_W-1:0] y,
                                          input logic [COORD_W-1:0] d,
                                          input logic eight,
                                          input logic [DIR_W-1:0] dir);
        logic signed [POS_W-1:0] sx;
        logic signed [POS_W-1:0] sy;
        logic signed [POS_W-1:0] sd;
        pos_t p;
        sx = signed'({2'b00, x});
        sy = signed'({2'b00, y});
        sd = signed'({2'b00, d});
        p.nx = sx;
        p.ny = sy;
        if (eight) begin
            case (dir)
                3'd0: p.ny = sy - sd;
                3'd1: begin p.nx = sx + sd; p.ny = sy - sd; end
                3'd2: p.nx = sx + sd;
                3'd3: begin p.nx = sx + sd; p.ny = sy + sd; end
                3'd4: p.ny = sy + sd;
                3'd5: begin p.nx = sx - sd; p.ny = sy + sd; end
                3'd6: p.nx = sx - sd;
                default: begin p.nx = sx - sd; p.ny = sy - sd; end
            endcase
        end else begin
            case (dir[1:0])
                2'd0: p.nx = sx + sd;
                2'd1: p.ny = sy + sd;
                2'd2: p.nx = sx - sd;
                default: p.ny = sy - sd;
            endcase
        end
        return p;
    endfunction

    function automatic logic in_grid(input pos_t p,
                                     input logic [DIM_W-1:0] w,
                                     input logic [DIM_W-1:0] h);
        return !p.nx[POS_W-1] && !p.ny[POS_W-1] &&
               (p.nx[DIM_W-1:0] < w) && (p.ny[DIM_W-1:0] < h);
    endfunction

endpackage

@@ rtl/grid_neighbor_finder.sv @@
// Channel  Direction  Handshake                 Payload
// s_       in         s_tvalid / s_tready       tdata: node_x, node_y, distance, flags; tuser: mode
// m_       out        m_tvalid / m_tready       tdata: neighbor_x, neighbor_y, direction; tuser: found
// cfg_     in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A write word is taken in the idle state. A cross query holds the input while its four neighbour
// cells, and an eight-way query while its eight, are read in turn through the single read port
// of the wall memory, plus accept, read latency and hand-off. Results leave at one word per cycle
// while m_tready is high, from an output register, as the next word is being scanned.
// Reset clears control state only; the wall memory is not cleared.
// A stalled result channel holds the scanner at hand-off until the emitter is free.
module grid_neighbor_finder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // node_x, node_y, distance, corner_needs_sides, wall_bit
    input  logic [1:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // neighbor_x, neighbor_y, direction
    output logic [0:0]  m_tuser,   // found
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

    logic [gnf_pkg::DIM_W-1:0]   grid_width_reg;
    logic [gnf_pkg::DIM_W-1:0]   grid_height_reg;
    logic [gnf_pkg::DIM_W-1:0]   grid_w;
    logic [gnf_pkg::DIM_W-1:0]   grid_h;
    gnf_pkg::ram_req_t           ram_req;
    logic                        ram_rdata;
    logic                        res_valid;
    logic                        res_ready;
    gnf_pkg::scan_res_t          res;
    logic                        found;
    logic [gnf_pkg::COORD_W-1:0] neighbor_x;
    logic [gnf_pkg::COORD_W-1:0] neighbor_y;
    logic [gnf_pkg::DIR_W-1:0]   direction;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= gnf_pkg::DIM_W'(gnf_pkg::MAX_WIDTH);
            grid_height_reg <= gnf_pkg::DIM_W'(gnf_pkg::MAX_HEIGHT);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                gnf_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                gnf_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign grid_w = (grid_width_reg > gnf_pkg::DIM_W'(gnf_pkg::MAX_WIDTH)) ?
                    gnf_pkg::DIM_W'(gnf_pkg::MAX_WIDTH) : grid_width_reg;
    assign grid_h = (grid_height_reg > gnf_pkg::DIM_W'(gnf_pkg::MAX_HEIGHT)) ?
                    gnf_pkg::DIM_W'(gnf_pkg::MAX_HEIGHT) : grid_height_reg;

    gnf_ram #(
        .ADDR_W (gnf_pkg::ADDR_W),
        .DATA_W (1)
    ) u_ram (
        .aclk    (aclk),
        .we      (ram_req.we),
        .waddr   (ram_req.waddr),
        .wdata   (ram_req.wdata),
        .raddr   (ram_req.raddr),
        .rd_data (ram_rdata)
    );

    gnf_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .item_bits (s_tdata[gnf_pkg::IN_BITS-1:0]),
        .mode      (s_tuser),
        .grid_w    (grid_w),
        .grid_h    (grid_h),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    gnf_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .found      (found),
        .neighbor_x (neighbor_x),
        .neighbor_y (neighbor_y),
        .direction  (direction),
        .last       (m_tlast)
    );

    assign m_tdata = {5'd0, direction, neighbor_y, neighbor_x};
    assign m_tuser = found;

endmodule

@@ rtl/gnf_ram.sv @@
module gnf_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/gnf_scan.sv @@
`include "grid_neighbor_finder_macros.svh"

module gnf_scan (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gnf_pkg::IN_BITS-1:0]   item_bits,
    input  logic [1:0]                    mode,
    input  logic [gnf_pkg::DIM_W-1:0]     grid_w,
    input  logic [gnf_pkg::DIM_W-1:0]     grid_h,
    output gnf_pkg::ram_req_t             ram_req,
    input  logic                          ram_rdata,
    output logic                          res_valid,
    input  logic                          res_ready,
    output gnf_pkg::scan_res_t            res
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_WAIT = 4'b0100,
        S_HAND = 4'b1000
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    gnf_pkg::in_item_t               item;
    logic                            accept;
    logic                            is_query;
    logic                            wr_inb;
    logic [gnf_pkg::COORD_W-1:0]     x_reg;
    logic [gnf_pkg::COORD_W-1:0]     y_reg;
    logic [gnf_pkg::COORD_W-1:0]     d_reg;
    logic                            eight_reg;
    logic                            sides_reg;
    logic [gnf_pkg::DIR_W-1:0]       idx_reg;
    logic [gnf_pkg::DIR_W-1:0]       last_idx;
    logic                            cap_act_reg;
    logic [gnf_pkg::DIR_W-1:0]       cap_idx_reg;
    logic                            cap_inb_reg;
    logic [gnf_pkg::NUM_DIRS-1:0]    open_reg;
    logic [gnf_pkg::NUM_DIRS-1:0]    mask;
    gnf_pkg::pos_t                   rd_pos;
    logic                            rd_inb;
    logic                            issue;

    assign item     = item_bits;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign issue    = (state_reg == S_READ);
    assign last_idx = eight_reg ? gnf_pkg::DIR_W'(7) : gnf_pkg::DIR_W'(3);

    always_comb begin
        unique case (mode)
            gnf_pkg::MODE_CROSS, gnf_pkg::MODE_EIGHT: is_query = 1'b1;
            default: is_query = 1'b0;
        endcase
    end

    assign wr_inb = ({1'b0, item.node_x} < grid_w) && ({1'b0, item.node_y} < grid_h);

    assign rd_pos = gnf_pkg::neighbor_pos(x_reg, y_reg, d_reg, eight_reg, idx_reg);
    assign rd_inb = gnf_pkg::in_grid(rd_pos, grid_w, grid_h);

    assign ram_req.we    = accept && (mode == gnf_pkg::MODE_WRITE) && wr_inb;
    assign ram_req.waddr = {item.node_y, item.node_x};
    assign ram_req.wdata = item.wall_bit;
    assign ram_req.raddr = {rd_pos.ny[gnf_pkg::COORD_W-1:0], rd_pos.nx[gnf_pkg::COORD_W-1:0]};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && is_query) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                if (idx_reg == last_idx) begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: state_next = S_HAND;
            S_HAND: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cap_act_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cap_act_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        cap_idx_reg <= idx_reg;
        cap_inb_reg <= rd_inb;
        if (accept) begin
            x_reg     <= item.node_x;
            y_reg     <= item.node_y;
            d_reg     <= item.distance;
            eight_reg <= (mode == gnf_pkg::MODE_EIGHT);
            sides_reg <= (mode == gnf_pkg::MODE_EIGHT) && item.corner_needs_sides;
            idx_reg   <= '0;
            open_reg  <= '0;
        end else if (issue) begin
            idx_reg <= idx_reg + gnf_pkg::DIR_W'(1);
        end
        if (cap_act_reg) begin
            open_reg[cap_idx_reg] <= cap_inb_reg && !ram_rdata;
        end
    end

    // A corner is kept only when both flanking side cells are open, if asked.
    always_comb begin
        for (int i = 0; i < gnf_pkg::NUM_DIRS; i++) begin
            mask[i] = open_reg[i];
            if ((i % 2 == 1) && sides_reg) begin
                mask[i] = open_reg[i] &&
                          open_reg[(i + gnf_pkg::NUM_DIRS - 1) % gnf_pkg::NUM_DIRS] &&
                          open_reg[(i + 1) % gnf_pkg::NUM_DIRS];
            end
        end
    end

    assign res_valid  = (state_reg == S_HAND);
    assign res.eight  = eight_reg;
    assign res.x      = x_reg;
    assign res.y      = y_reg;
    assign res.d      = d_reg;
    assign res.mask   = mask;

    `GNF_ASSERT_NEXT(a_wait_to_hand, aclk, aresetn, state_reg == S_WAIT, state_reg == S_HAND)
    `GNF_ASSERT_IMPL(a_read_bound, aclk, aresetn, state_reg == S_READ, idx_reg <= last_idx)
    `GNF_ASSERT_IMPL(a_cross_upper, aclk, aresetn, res_valid && !eight_reg, open_reg[7:4] == 4'd0)

endmodule

@@ rtl/gnf_emit.sv @@
`include "grid_neighbor_finder_macros.svh"

module gnf_emit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        res_valid,
    output logic                        res_ready,
    input  gnf_pkg::scan_res_t          res,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic                        found,
    output logic [gnf_pkg::COORD_W-1:0] neighbor_x,
    output logic [gnf_pkg::COORD_W-1:0] neighbor_y,
    output logic [gnf_pkg::DIR_W-1:0]   direction,
    output logic                        last
);

    logic                          busy_reg;
    logic                          nf_reg;
    logic [gnf_pkg::NUM_DIRS-1:0]  mask_reg;
    logic [gnf_pkg::NUM_DIRS-1:0]  mask_rest;
    logic                          eight_reg;
    logic [gnf_pkg::COORD_W-1:0]   x_reg;
    logic [gnf_pkg::COORD_W-1:0]   y_reg;
    logic [gnf_pkg::COORD_W-1:0]   d_reg;
    logic                          m_tvalid_reg;
    logic                          found_reg;
    logic [gnf_pkg::COORD_W-1:0]   nx_reg;
    logic [gnf_pkg::COORD_W-1:0]   ny_reg;
    logic [gnf_pkg::DIR_W-1:0]     dir_reg;
    logic                          last_reg;
    logic [gnf_pkg::DIR_W-1:0]     dir_sel;
    gnf_pkg::pos_t                 pos;
    logic                          take;
    logic                          out_free;
    logic                          step;
    logic                          final_word;

    assign res_ready  = !busy_reg;
    assign take       = res_valid && res_ready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign step       = busy_reg && out_free;

    always_comb begin
        dir_sel = '0;
        for (int i = gnf_pkg::NUM_DIRS - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                dir_sel = gnf_pkg::DIR_W'(i);
            end
        end
    end

    assign mask_rest  = mask_reg & ~(gnf_pkg::NUM_DIRS'(1) << dir_sel);
    assign final_word = nf_reg || (mask_rest == '0);
    assign pos        = gnf_pkg::neighbor_pos(x_reg, y_reg, d_reg, eight_reg, dir_sel);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (take) begin
                busy_reg <= 1'b1;
            end else if (step && final_word) begin
                busy_reg <= 1'b0;
            end
            if (step) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            mask_reg  <= res.mask;
            nf_reg    <= (res.mask == '0);
            eight_reg <= res.eight;
            x_reg     <= res.x;
            y_reg     <= res.y;
            d_reg     <= res.d;
        end else if (step) begin
            mask_reg <= mask_rest;
        end
        if (step) begin
            found_reg <= !nf_reg;
            nx_reg    <= nf_reg ? '0 : pos.nx[gnf_pkg::COORD_W-1:0];
            ny_reg    <= nf_reg ? '0 : pos.ny[gnf_pkg::COORD_W-1:0];
            dir_reg   <= nf_reg ? '0 : dir_sel;
            last_reg  <= final_word;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign found      = found_reg;
    assign neighbor_x = nx_reg;
    assign neighbor_y = ny_reg;
    assign direction  = dir_reg;
    assign last       = last_reg;

    `GNF_ASSERT_IMPL(a_nf_word, aclk, aresetn, m_tvalid_reg && !found_reg, last_reg && nx_reg == '0 && ny_reg == '0 && dir_reg == '0)
    `GNF_ASSERT_IMPL(a_nf_mask, aclk, aresetn, busy_reg && nf_reg, mask_reg == '0)
    `GNF_ASSERT_NEXT(a_release, aclk, aresetn, step && final_word, !busy_reg)

endmodule
